// File: hdl/ysr_pkg.sv
// ----------------------------------------------------------------------------
// ysr_pkg
// Shared types, constants and helpers for the scaled YUYV readback block.
// ----------------------------------------------------------------------------
package ysr_pkg;

    // Default largest supported image side
    localparam int YSR_MAX_SIDE = 1024;

    // Fixed field widths
    localparam int REG_W   = 11;
    localparam int OFS_W   = 21;
    localparam int COLOR_W = 8;
    localparam int IDX_W   = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    // Register reset values
    localparam logic [REG_W-1:0] RST_SRC_WIDTH  = 11'd640;
    localparam logic [REG_W-1:0] RST_SRC_HEIGHT = 11'd480;
    localparam logic [REG_W-1:0] RST_DST_WIDTH  = 11'd640;
    localparam logic [REG_W-1:0] RST_DST_HEIGHT = 11'd480;

    // Input word actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // BT.601 studio range to RGB, 8.8 fixed point
    localparam int COEF_Y     = 298;
    localparam int COEF_R_CR  = 409;
    localparam int COEF_G_CB  = 100;
    localparam int COEF_G_CR  = 208;
    localparam int COEF_B_CB  = 516;
    localparam int ROUND_HALF = 128;
    localparam int LUMA_OFS   = 16;
    localparam int CHROMA_OFS = 128;

    typedef struct packed {
        logic               action;
        logic [COLOR_W-1:0] luma_first;
        logic [COLOR_W-1:0] chroma_blue;
        logic [COLOR_W-1:0] luma_second;
        logic [COLOR_W-1:0] chroma_red;
    } ysr_in_t;

    typedef struct packed {
        logic               pixel_valid;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [OFS_W-1:0]   fetch_offset;
        logic               last_pixel;
    } ysr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRODUCT,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_OFFSET,
        ST_RESULT
    } ysr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic product_en;
        logic div_start;
        logic offset_en;
        logic result_load;
    } ysr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_locate;
        logic div_done;
        logic out_free;
    } ysr_status_t;

    // Floor by 256 and clamp to 0..255
    function automatic logic [COLOR_W-1:0] clamp_channel(input logic signed [18:0] v);
        logic [COLOR_W-1:0] res;
        begin
            if (v[18]) begin
                res = '0;
            end else if (|v[17:16]) begin
                res = '1;
            end else begin
                res = v[15:8];
            end
            return res;
        end
    endfunction

endpackage

// File: hdl/yuyv_scaled_readback_to_rgb.sv
// ----------------------------------------------------------------------------
// yuyv_scaled_readback_to_rgb
// Nearest-neighbor scaled readback of a packed Y1 Cb Y2 Cr buffer as RGB.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: a start word (action 0) restarts the walk at pixel (0,0) and
//   returns the first pair offset. Each fetch word (action 1) carries the pair
//   at the last returned offset; the block returns the converted pixel and the
//   offset of the pair for the next destination pixel (0 with last_pixel on
//   the final one). A fetch word while no walk runs returns an all-zero word.
//   m_ channel: one word per input word, in order.
//   cfg_ port: sizes, written while the block is idle.
// Timing: a word that needs a new offset passes the product, divider load,
//   divide, offset and result states before m_valid rises; the two serial
//   dividers, one quotient bit a cycle, run side by side in the divide state.
//   Other words go from the product state straight to the result state. The
//   next word is accepted in the cycle after a result loads.
// Reset: sizes return to 640x480 both sides, the walk goes idle, no word out.
// Stall: the result waits in the output register; the block takes and works
//   on the next word meanwhile and holds before loading its result.
// ----------------------------------------------------------------------------
module yuyv_scaled_readback_to_rgb import ysr_pkg::*; #(
    parameter int MAX_SIDE = YSR_MAX_SIDE
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  ysr_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ysr_out_t         m_data
);

    ysr_cmd_t    cmd;
    ysr_status_t status;

    ysr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ysr_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hdl/ysr_div.sv
// ----------------------------------------------------------------------------
// ysr_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ysr_div #(
    parameter int DW = 21,
    parameter int VW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [DW-1:0]   quot_reg, quot_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   div_reg;
    logic [VW:0]     trial;
    logic            fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quot_reg[DW-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next  = CNTW'(DW);
            quot_next = dividend;
            rem_next  = '0;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - CNTW'(1);
            quot_next = {quot_reg[DW-2:0], fits};
            rem_next  = fits ? VW'(trial - {1'b0, div_reg}) : trial[VW-1:0];
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

// File: hdl/ysr_datapath.sv
// ----------------------------------------------------------------------------
// ysr_datapath
// Size registers, walk counters, source locator and color conversion.
// ----------------------------------------------------------------------------
module ysr_datapath import ysr_pkg::*; #(
    parameter int MAX_SIDE = YSR_MAX_SIDE
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]   cfg_data,
    input  ysr_in_t            s_data,
    input  ysr_cmd_t           cmd,
    output ysr_status_t        status,
    output logic               m_valid,
    input  logic               m_ready,
    output ysr_out_t           m_data
);

    localparam int CW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int PW   = CW + SW;
    localparam int CMPW = (SW > REG_W) ? SW : REG_W;
    localparam int LW   = OFS_W - 1;

    // Size registers
    logic [REG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= RST_SRC_WIDTH;
            src_h_reg <= RST_SRC_HEIGHT;
            dst_w_reg <= RST_DST_WIDTH;
            dst_h_reg <= RST_DST_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_w_reg <= cfg_data;
                CFG_SRC_HEIGHT: src_h_reg <= cfg_data;
                CFG_DST_WIDTH:  dst_w_reg <= cfg_data;
                CFG_DST_HEIGHT: dst_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero counts as one, anything above the largest side as that side
    function automatic logic [SW-1:0] eff_side(input logic [REG_W-1:0] v);
        logic [CMPW-1:0] ext;
        logic [SW-1:0]   res;
        begin
            ext = CMPW'(v);
            if (ext == '0) begin
                res = SW'(1);
            end else if (ext > CMPW'(MAX_SIDE)) begin
                res = SW'(MAX_SIDE);
            end else begin
                res = SW'(ext);
            end
            return res;
        end
    endfunction

    logic [SW-1:0] sw, sh, dw, dh;
    assign sw = eff_side(src_w_reg);
    assign sh = eff_side(src_h_reg);
    assign dw = eff_side(dst_w_reg);
    assign dh = eff_side(dst_h_reg);

    // Walk state and captured word
    logic [CW-1:0]      col_reg, row_reg;
    logic               active_reg, odd_reg;
    logic               pix_reg, last_reg, need_reg;
    logic [COLOR_W-1:0] y_reg, cb_reg, cr_reg;
    logic               line_end, image_end;
    logic               div_done_x, div_done_y;
    logic [PW-1:0]      sx, sy;

    assign line_end  = ((SW+1)'(col_reg) + (SW+1)'(1)) >= (SW+1)'(dw);
    assign image_end = line_end && (((SW+1)'(row_reg) + (SW+1)'(1)) >= (SW+1)'(dh));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            active_reg <= 1'b0;
            odd_reg    <= 1'b0;
            pix_reg    <= 1'b0;
            last_reg   <= 1'b0;
            need_reg   <= 1'b0;
        end else if (cmd.accept) begin
            if (s_data.action == ACT_START) begin
                col_reg    <= '0;
                row_reg    <= '0;
                active_reg <= 1'b1;
                pix_reg    <= 1'b0;
                last_reg   <= 1'b0;
                need_reg   <= 1'b1;
            end else if (!active_reg) begin
                pix_reg  <= 1'b0;
                last_reg <= 1'b0;
                need_reg <= 1'b0;
            end else begin
                pix_reg <= 1'b1;
                if (image_end) begin
                    last_reg   <= 1'b1;
                    need_reg   <= 1'b0;
                    active_reg <= 1'b0;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    odd_reg    <= 1'b0;
                end else begin
                    last_reg <= 1'b0;
                    need_reg <= 1'b1;
                    if (line_end) begin
                        col_reg <= '0;
                        row_reg <= row_reg + CW'(1);
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
            end
        end else if (div_done_x) begin
            odd_reg <= sx[0];
        end
    end

    // Pixel bytes; luma picked by the parity of the current source column
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            y_reg  <= odd_reg ? s_data.luma_second : s_data.luma_first;
            cb_reg <= s_data.chroma_blue;
            cr_reg <= s_data.chroma_red;
        end
    end

    // Scale products for the source position
    logic [PW-1:0] xprod_reg, yprod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.product_en) begin
            xprod_reg <= PW'(col_reg) * PW'(sw);
            yprod_reg <= PW'(row_reg) * PW'(sh);
        end
    end

    // Two serial dividers, run side by side
    ysr_div #(.DW(PW), .VW(SW)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (xprod_reg),
        .divisor  (dw),
        .quotient (sx),
        .done     (div_done_x)
    );

    ysr_div #(.DW(PW), .VW(SW)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (yprod_reg),
        .divisor  (dh),
        .quotient (sy),
        .done     (div_done_y)
    );

    // Pair offset: line base product, then even column added at load
    logic [LW-1:0] base_reg, sxe_reg;

    always_ff @(posedge aclk) begin
        if (cmd.offset_en) begin
            base_reg <= LW'(LW'(sy) * LW'(sw));
            sxe_reg  <= LW'({sx[PW-1:1], 1'b0});
        end
    end

    // Color products
    logic signed [9:0]  c_s, d_s, e_s;
    logic signed [18:0] pc_reg, pre_reg, pgd_reg, pge_reg, pbd_reg;
    logic signed [18:0] r_sum, g_sum, b_sum;

    assign c_s = $signed({2'b00, y_reg})  - 10'(LUMA_OFS);
    assign d_s = $signed({2'b00, cb_reg}) - 10'(CHROMA_OFS);
    assign e_s = $signed({2'b00, cr_reg}) - 10'(CHROMA_OFS);

    always_ff @(posedge aclk) begin
        if (cmd.product_en) begin
            pc_reg  <= 19'(c_s) * 19'(COEF_Y);
            pre_reg <= 19'(e_s) * 19'(COEF_R_CR);
            pgd_reg <= 19'(d_s) * 19'(COEF_G_CB);
            pge_reg <= 19'(e_s) * 19'(COEF_G_CR);
            pbd_reg <= 19'(d_s) * 19'(COEF_B_CB);
        end
    end

    assign r_sum = pc_reg + pre_reg + 19'(ROUND_HALF);
    assign g_sum = pc_reg - pgd_reg - pge_reg + 19'(ROUND_HALF);
    assign b_sum = pc_reg + pbd_reg + 19'(ROUND_HALF);

    // Output register
    logic     m_valid_reg, m_valid_next;
    ysr_out_t m_data_reg, m_data_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        m_data_next.pixel_valid  = pix_reg;
        m_data_next.red          = pix_reg ? clamp_channel(r_sum) : '0;
        m_data_next.green        = pix_reg ? clamp_channel(g_sum) : '0;
        m_data_next.blue         = pix_reg ? clamp_channel(b_sum) : '0;
        m_data_next.fetch_offset = need_reg ? {LW'(base_reg + sxe_reg), 1'b0} : '0;
        m_data_next.last_pixel   = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.need_locate = need_reg;
    assign status.div_done    = div_done_x & div_done_y;
    assign status.out_free    = !m_valid_reg || m_ready;

    // Checks
    a_idle_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (col_reg == '0) && (row_reg == '0))
        else $error("walk idle but counters not at origin");

    a_blank_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.pixel_valid |->
            (m_data_reg.red == '0) && (m_data_reg.green == '0) &&
            (m_data_reg.blue == '0) && !m_data_reg.last_pixel)
        else $error("word without pixel carries color or last flag");

    a_last_no_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.last_pixel |-> (m_data_reg.fetch_offset == '0))
        else $error("last pixel requests a further fetch");

endmodule

// File: hdl/ysr_ctrl.sv
// ----------------------------------------------------------------------------
// ysr_ctrl
// Sequencer: accept, products, divide and offset when a new offset is needed, deliver.
// ----------------------------------------------------------------------------
module ysr_ctrl import ysr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ysr_status_t status,
    output ysr_cmd_t    cmd
);

    ysr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PRODUCT;
                end
            end
            ST_PRODUCT: begin
                cmd.product_en = 1'b1;
                state_next     = status.need_locate ? ST_DIV_LOAD : ST_RESULT;
            end
            ST_DIV_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET: begin
                cmd.offset_en = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_PRODUCT))
        else $error("accepted word did not enter product stage");

    a_div_done_place: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside divide state");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> status.out_free)
        else $error("result loaded over a pending word");

endmodule

// File: bench/tb_yuyv_scaled_readback_to_rgb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yuyv_scaled_readback_to_rgb
// Self-checking bench for the scaled YUYV readback to RGB converter. A short
// table of directed words covers reset sizes, out-of-range sizes, a
// one-pixel image, size changes in the middle of a walk and color extremes.
// Random walks with random pair contents and some stray words follow. Every
// word is predicted by a local model of the walk and the color conversion,
// and each result word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_yuyv_scaled_readback_to_rgb import ysr_pkg::*;;

    localparam int TOTAL_WORDS    = 1150;
    localparam int WALK_CAP       = 40;
    localparam int IDLE_PCT       = 26;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_PAUSE      = 40;
    localparam int PRINT_CAP      = 40;

    // Results that can be read straight off the conversion
    localparam ysr_out_t EMPTY_WORD = '0;
    localparam ysr_out_t WHITE_AT_0 = '{pixel_valid: 1'b1, red: 8'hFF, green: 8'hFF,
                                        blue: 8'hFF, fetch_offset: '0, last_pixel: 1'b0};
    localparam ysr_out_t BLACK_AT_4 = '{pixel_valid: 1'b1, red: 8'h00, green: 8'h00,
                                        blue: 8'h00, fetch_offset: 21'd4, last_pixel: 1'b0};
    localparam ysr_out_t WHITE_LAST = '{pixel_valid: 1'b1, red: 8'hFF, green: 8'hFF,
                                        blue: 8'hFF, fetch_offset: '0, last_pixel: 1'b1};

    typedef struct {
        bit               reg_write;
        logic [IDX_W-1:0] reg_idx;
        logic [REG_W-1:0] reg_val;
        ysr_in_t          word;
        bit               known;
        ysr_out_t         result;
    } directed_row_t;

    // DUT signals
    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = CFG_SRC_WIDTH;
    logic [REG_W-1:0] cfg_data  = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    ysr_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    ysr_out_t         m_data;

    // Walk model: sizes, position and luma select
    logic [REG_W-1:0] size_reg [4];
    int unsigned      walk_col;
    int unsigned      walk_row;
    bit               walk_on;
    bit               use_second;

    ysr_out_t      pixel_q [$];
    directed_row_t plan [$];
    logic [IDX_W-1:0] reg_order [4] = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT,
                                        CFG_DST_WIDTH, CFG_DST_HEIGHT};

    int  error_count   = 0;
    int  words_sent    = 0;
    int  ignored_words = 0;
    int  results_seen  = 0;
    int  pixels_seen   = 0;
    int  images_done   = 0;
    int  reg_writes    = 0;
    int  idle_cycles   = 0;
    logic steady;

    // No idling on either side for a stretch in the middle of the run
    assign steady = (words_sent >= 450) && (words_sent < 650);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    yuyv_scaled_readback_to_rgb u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ------------------------------------------------------------------
    // Walk and color model
    // ------------------------------------------------------------------
    function automatic int unsigned clip_side(input logic [REG_W-1:0] v);
        if (v == '0) return 1;
        if (32'(v) > YSR_MAX_SIDE) return YSR_MAX_SIDE;
        return 32'(v);
    endfunction

    // Source pair offset for the current destination pixel; picks the luma
    function automatic logic [OFS_W-1:0] locate_pair();
        int unsigned sw, sh, dw, dh, sx, sy, ofs;
        sw  = clip_side(size_reg[CFG_SRC_WIDTH]);
        sh  = clip_side(size_reg[CFG_SRC_HEIGHT]);
        dw  = clip_side(size_reg[CFG_DST_WIDTH]);
        dh  = clip_side(size_reg[CFG_DST_HEIGHT]);
        sx  = (walk_col * sw) / dw;
        sy  = (walk_row * sh) / dh;
        use_second = sx[0];
        ofs = (sy * sw + (sx & ~32'd1)) * 2;
        return ofs[OFS_W-1:0];
    endfunction

    // Floor of the 8.8 value, saturated to one byte
    function automatic logic [COLOR_W-1:0] sat_channel(input int v);
        if (v < 0) return '0;
        if ((v >>> 8) > 255) return '1;
        return COLOR_W'(v >>> 8);
    endfunction

    function automatic ysr_out_t predict_pixel(input ysr_in_t w);
        ysr_out_t r;
        int luma, cy, cb, cr;
        int unsigned dw, dh;
        bit eol, eoi;
        r = '0;
        if (w.action == ACT_START) begin
            walk_col = 0;
            walk_row = 0;
            walk_on  = 1'b1;
            r.fetch_offset = locate_pair();
            return r;
        end
        if (!walk_on) return r;
        luma = use_second ? int'(w.luma_second) : int'(w.luma_first);
        cy   = luma - LUMA_OFS;
        cb   = int'(w.chroma_blue) - CHROMA_OFS;
        cr   = int'(w.chroma_red) - CHROMA_OFS;
        r.pixel_valid = 1'b1;
        r.red   = sat_channel(COEF_Y * cy + COEF_R_CR * cr + ROUND_HALF);
        r.green = sat_channel(COEF_Y * cy - COEF_G_CB * cb - COEF_G_CR * cr + ROUND_HALF);
        r.blue  = sat_channel(COEF_Y * cy + COEF_B_CB * cb + ROUND_HALF);
        dw  = clip_side(size_reg[CFG_DST_WIDTH]);
        dh  = clip_side(size_reg[CFG_DST_HEIGHT]);
        eol = (walk_col + 1) >= dw;
        eoi = eol && ((walk_row + 1) >= dh);
        if (eoi) begin
            r.last_pixel = 1'b1;
            walk_on    = 1'b0;
            walk_col   = 0;
            walk_row   = 0;
            use_second = 1'b0;
            return r;
        end
        if (eol) begin
            walk_col = 0;
            walk_row = walk_row + 1;
        end else begin
            walk_col = walk_col + 1;
        end
        r.fetch_offset = locate_pair();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Table rows and random words
    // ------------------------------------------------------------------
    function automatic directed_row_t reg_row(input logic [IDX_W-1:0] idx,
                                              input logic [REG_W-1:0] val);
        directed_row_t r;
        r = '{default: '0};
        r.reg_write = 1'b1;
        r.reg_idx   = idx;
        r.reg_val   = val;
        return r;
    endfunction

    function automatic directed_row_t word_row(input logic act, input logic [7:0] y1,
                                               input logic [7:0] cb, input logic [7:0] y2,
                                               input logic [7:0] cr);
        directed_row_t r;
        r = '{default: '0};
        r.word = '{action: act, luma_first: y1, chroma_blue: cb,
                   luma_second: y2, chroma_red: cr};
        return r;
    endfunction

    function automatic directed_row_t known_row(input directed_row_t r, input ysr_out_t res);
        directed_row_t k;
        k        = r;
        k.known  = 1'b1;
        k.result = res;
        return k;
    endfunction

    function automatic ysr_in_t random_word(input logic act);
        ysr_in_t w;
        w.action      = act;
        w.luma_first  = COLOR_W'($urandom());
        w.chroma_blue = COLOR_W'($urandom());
        w.luma_second = COLOR_W'($urandom());
        w.chroma_red  = COLOR_W'($urandom());
        return w;
    endfunction

    // Small destination sides, source sides up to the top code; now and then zero, the top code or the largest side
    function automatic logic [REG_W-1:0] pick_size(input bit dest);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 12) return '1;
        if (r < 18) return REG_W'(YSR_MAX_SIDE);
        if (dest) return REG_W'((r < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7));
        if (r < 90) return REG_W'($urandom_range(YSR_MAX_SIDE, 1));
        return REG_W'($urandom_range((1 << REG_W) - 1, YSR_MAX_SIDE + 1));
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("ERROR t=%0t result %0d: %s", $time, results_seen, msg);
    endtask

    // Present one input word, wait for accept, queue its expected result
    task automatic send_word(input ysr_in_t w, input bit known, input ysr_out_t given);
        ysr_out_t want;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.action == ACT_FETCH && !walk_on) ignored_words++;
        else words_sent++;
        want = predict_pixel(w);
        pixel_q.push_back(known ? given : want);
    endtask

    // Stop sending and wait until every expected word is back
    task automatic settle();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        size_reg[idx] = val;
        reg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and in-order compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        ysr_out_t want;
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                flag_error("result word with nothing expected");
            end else begin
                want = pixel_q.pop_front();
                if (m_data.pixel_valid !== want.pixel_valid)
                    flag_error($sformatf("pixel_valid got %0b expected %0b",
                                         m_data.pixel_valid, want.pixel_valid));
                if (m_data.red !== want.red)
                    flag_error($sformatf("red got %0d expected %0d", m_data.red, want.red));
                if (m_data.green !== want.green)
                    flag_error($sformatf("green got %0d expected %0d",
                                         m_data.green, want.green));
                if (m_data.blue !== want.blue)
                    flag_error($sformatf("blue got %0d expected %0d", m_data.blue, want.blue));
                if (m_data.fetch_offset !== want.fetch_offset)
                    flag_error($sformatf("fetch_offset got %0d expected %0d",
                                         m_data.fetch_offset, want.fetch_offset));
                if (m_data.last_pixel !== want.last_pixel)
                    flag_error($sformatf("last_pixel got %0b expected %0b",
                                         m_data.last_pixel, want.last_pixel));
                if (want.pixel_valid) pixels_seen++;
                if (want.last_pixel) images_done++;
            end
            results_seen++;
        end
    end

    // Watchdog: too long without a word moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int fetches;
        bit is_dest;
        size_reg[CFG_SRC_WIDTH]  = RST_SRC_WIDTH;
        size_reg[CFG_SRC_HEIGHT] = RST_SRC_HEIGHT;
        size_reg[CFG_DST_WIDTH]  = RST_DST_WIDTH;
        size_reg[CFG_DST_HEIGHT] = RST_DST_HEIGHT;
        walk_col   = 0;
        walk_row   = 0;
        walk_on    = 1'b0;
        use_second = 1'b0;

        plan = '{
            // reset sizes: stray fetch, start, even then odd luma, color extremes
            known_row(word_row(ACT_FETCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF), EMPTY_WORD),
            known_row(word_row(ACT_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF), EMPTY_WORD),
            known_row(word_row(ACT_FETCH, 8'd235, 8'd128, 8'd16, 8'd128), WHITE_AT_0),
            known_row(word_row(ACT_FETCH, 8'd255, 8'd128, 8'd16, 8'd128), BLACK_AT_4),
            word_row(ACT_FETCH, 8'h00, 8'h00, 8'h00, 8'h00),
            word_row(ACT_FETCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
            word_row(ACT_FETCH, 8'h00, 8'hFF, 8'h00, 8'h00),
            word_row(ACT_FETCH, 8'hFF, 8'h00, 8'hFF, 8'hFF),
            // restart in the middle of a walk
            known_row(word_row(ACT_START, 8'h00, 8'h00, 8'h00, 8'h00), EMPTY_WORD),
            // zero and top-code sizes, single pixel image, fetch after the end
            reg_row(CFG_SRC_WIDTH, '0),
            reg_row(CFG_SRC_HEIGHT, '1),
            reg_row(CFG_DST_WIDTH, REG_W'(1)),
            reg_row(CFG_DST_HEIGHT, REG_W'(1)),
            known_row(word_row(ACT_START, 8'h5A, 8'hA5, 8'h5A, 8'hA5), EMPTY_WORD),
            known_row(word_row(ACT_FETCH, 8'd235, 8'd128, 8'd0, 8'd128), WHITE_LAST),
            known_row(word_row(ACT_FETCH, 8'h5A, 8'hA5, 8'h5A, 8'hA5), EMPTY_WORD),
            // largest sides, then the line shrinks under the running walk
            reg_row(CFG_SRC_WIDTH, REG_W'(YSR_MAX_SIDE)),
            reg_row(CFG_SRC_HEIGHT, REG_W'(YSR_MAX_SIDE)),
            reg_row(CFG_DST_WIDTH, '1),
            reg_row(CFG_DST_HEIGHT, REG_W'(2)),
            word_row(ACT_START, 8'h00, 8'h00, 8'h00, 8'h00),
            word_row(ACT_FETCH, 8'd16, 8'd128, 8'd235, 8'd128),
            reg_row(CFG_DST_WIDTH, REG_W'(1)),
            word_row(ACT_FETCH, 8'd81, 8'd90, 8'd81, 8'd240),
            word_row(ACT_FETCH, 8'd145, 8'd54, 8'd145, 8'd34),
            // upscale 3x2 to 4x3
            reg_row(CFG_SRC_WIDTH, REG_W'(3)),
            reg_row(CFG_SRC_HEIGHT, REG_W'(2)),
            reg_row(CFG_DST_WIDTH, REG_W'(4)),
            reg_row(CFG_DST_HEIGHT, REG_W'(3)),
            word_row(ACT_START, 8'h00, 8'h00, 8'h00, 8'h00),
            word_row(ACT_FETCH, 8'd16, 8'd128, 8'd16, 8'd128),
            word_row(ACT_FETCH, 8'd235, 8'd16, 8'd235, 8'd240),
            word_row(ACT_FETCH, 8'd81, 8'd90, 8'd81, 8'd240),
            word_row(ACT_FETCH, 8'd145, 8'd54, 8'd145, 8'd34),
            word_row(ACT_FETCH, 8'd41, 8'd240, 8'd41, 8'd110),
            word_row(ACT_FETCH, 8'd128, 8'd128, 8'd200, 8'd128)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (plan[k]) begin
            if (plan[k].reg_write) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_word(plan[k].word, plan[k].known, plan[k].result);
            end
        end

        // Random phases: new sizes, then a few walks or stray words
        while (words_sent < TOTAL_WORDS) begin
            settle();
            foreach (reg_order[i]) begin
                is_dest = (reg_order[i] == CFG_DST_WIDTH) || (reg_order[i] == CFG_DST_HEIGHT);
                if ($urandom_range(2) != 0) write_reg(reg_order[i], pick_size(is_dest));
            end
            repeat ($urandom_range(4, 1)) begin
                if ($urandom_range(99) < 78) begin
                    // well-formed walk, sometimes picking up one left running
                    if (!walk_on || $urandom_range(4) != 0)
                        send_word(random_word(ACT_START), 1'b0, EMPTY_WORD);
                    fetches = 0;
                    while (walk_on && fetches < WALK_CAP && words_sent < TOTAL_WORDS) begin
                        send_word(random_word(ACT_FETCH), 1'b0, EMPTY_WORD);
                        fetches++;
                        if ($urandom_range(99) == 0) break;
                    end
                end else begin
                    repeat ($urandom_range(3, 1))
                        send_word(random_word($urandom_range(1) ? ACT_FETCH : ACT_START),
                                  1'b0, EMPTY_WORD);
                end
            end
        end

        settle();
        repeat (END_PAUSE) @(posedge aclk);

        $display("Run: %0d words drove the walk, %0d stray fetches, %0d register writes.",
                 words_sent, ignored_words, reg_writes);
        $display("Run: %0d result words checked, %0d pixels converted, %0d images finished.",
                 results_seen, pixels_seen, images_done);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ysr_pkg.sv
hdl/ysr_div.sv
hdl/ysr_datapath.sv
hdl/ysr_ctrl.sv
hdl/yuyv_scaled_readback_to_rgb.sv
bench/tb_yuyv_scaled_readback_to_rgb.sv
